/* rtl/core/mfiep_pkg.sv */
`default_nettype none

package mfiep_pkg;

  // Fixed sizes of the frame format.
  localparam int unsigned SSID_BYTES = 32;
  localparam int unsigned COUNT_BITS = 12;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned RATE_BITS  = 128;

  // Minimum body lengths and positions of the fixed fields.
  localparam int unsigned FIXED_LEN = 12;
  localparam int unsigned FIXED_OFS = 8;
  localparam int unsigned AUTH_LEN  = 6;

  // Element limits.
  localparam int unsigned RATES_MAX_LEN   = 8;
  localparam int unsigned CHANNEL_LEN     = 1;
  localparam int unsigned RATE_IGNORE_MIN = 126;

  // Management subtypes.
  localparam logic [3:0] SUBTYPE_PROBE_RESP = 4'd5;
  localparam logic [3:0] SUBTYPE_AUTH       = 4'd11;

  // Element identifiers.
  localparam logic [7:0] EID_SSID      = 8'd0;
  localparam logic [7:0] EID_RATES     = 8'd1;
  localparam logic [7:0] EID_CHANNEL   = 8'd3;
  localparam logic [7:0] EID_EXT_RATES = 8'd50;

  // Word positions within a record.
  localparam logic [2:0] WORD_FIXED      = 3'd0;
  localparam logic [2:0] WORD_BSSID      = 3'd1;
  localparam logic [2:0] WORD_SSID0      = 3'd2;
  localparam logic [2:0] WORD_RATE_LO    = 3'd6;
  localparam logic [2:0] WORD_RATE_HI    = 3'd7;
  localparam logic [2:0] WORD_LAST_PROBE = 3'd7;
  localparam logic [2:0] WORD_LAST_AUTH  = 3'd1;

  // Depth of the record queue between parser and word sequencer.
  localparam int unsigned REC_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_FIXED = 2'd0,
    PH_ID    = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } phase_e;

  typedef enum logic {
    KIND_PROBE = 1'b0,
    KIND_AUTH  = 1'b1
  } kind_e;

  // One parsed frame, ready to be sent out word by word.
  typedef struct packed {
    kind_e                     kind;
    logic [WORD_W-1:0]         word0;
    logic [ADDR_W-1:0]         bssid;
    logic [8*SSID_BYTES-1:0]   ssid;
    logic [RATE_BITS-1:0]      rates;
  } rec_t;

endpackage

`default_nettype wire

/* rtl/core/mfiep_front.sv */
`default_nettype none

module mfiep_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mfiep_pkg::ADDR_W-1:0]  cfg_data_i,
  input  wire logic                          accept_i,
  input  wire logic [3:0]                    frame_subtype_i,
  input  wire logic [mfiep_pkg::ADDR_W-1:0]  receiver_address_i,
  input  wire logic [mfiep_pkg::ADDR_W-1:0]  transmitter_address_i,
  input  wire logic [mfiep_pkg::ADDR_W-1:0]  bssid_address_i,
  input  wire logic [7:0]                    body_byte_i,
  input  wire logic                          last_byte_i,
  output logic                               rec_push_o,
  output mfiep_pkg::rec_t                    rec_o
);
  import mfiep_pkg::*;

  localparam int unsigned SLEN_W = $clog2(SSID_BYTES + 1);
  localparam int unsigned SIDX_W = $clog2(SSID_BYTES);

  logic [ADDR_W-1:0]     own_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  phase_e                phase_q, phase_d;
  logic [7:0]            eid_q, eid_d;
  logic [7:0]            rem_q, rem_d;
  logic [SLEN_W-1:0]     widx_q, widx_d;
  logic                  rej_q, rej_d;
  logic                  err_q, err_d;
  logic [31:0]           fixed_q, fixed_d;
  logic [47:0]           auth_q, auth_d;
  logic [7:0]            chan_q, chan_d;
  logic [SLEN_W-1:0]     slen_q, slen_d;
  logic [RATE_BITS-1:0]  rates_q, rates_d;
  logic [7:0]            ssid_q [SSID_BYTES];
  logic                  ssid_we;
  logic [6:0]            rate;
  logic                  probe_ok, auth_ok;
  logic [7:0]            ssid_byte;

  always_comb begin
    count_d = (count_q == '1) ? count_q : count_q + 1'b1;
    phase_d = phase_q;
    eid_d   = eid_q;
    rem_d   = rem_q;
    widx_d  = widx_q;
    err_d   = err_q;
    fixed_d = fixed_q;
    auth_d  = auth_q;
    chan_d  = chan_q;
    slen_d  = slen_q;
    rates_d = rates_q;
    ssid_we = 1'b0;
    rate    = body_byte_i[6:0];
    rej_d   = rej_q || (transmitter_address_i != bssid_address_i)
                    || (receiver_address_i != own_q);

    if (count_q < COUNT_BITS'(AUTH_LEN)) begin
      auth_d[{count_q[2:0], 3'b000} +: 8] = body_byte_i;
    end

    case (phase_q)
      PH_FIXED: begin
        if (count_q >= COUNT_BITS'(FIXED_OFS) && count_q < COUNT_BITS'(FIXED_LEN)) begin
          fixed_d[{count_q[1:0], 3'b000} +: 8] = body_byte_i;
          if (count_q == COUNT_BITS'(FIXED_LEN - 1)) begin
            phase_d = PH_ID;
          end
        end
      end
      PH_ID: begin
        eid_d   = body_byte_i;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        rem_d = body_byte_i;
        if (eid_q == EID_SSID) begin
          if (body_byte_i > 8'(SSID_BYTES)) begin
            err_d = 1'b1;
          end else begin
            slen_d = SLEN_W'(body_byte_i);
            widx_d = '0;
          end
        end else if (eid_q == EID_CHANNEL) begin
          if (body_byte_i != 8'(CHANNEL_LEN)) err_d = 1'b1;
        end else if (eid_q == EID_RATES) begin
          if (body_byte_i > 8'(RATES_MAX_LEN)) err_d = 1'b1;
        end
        phase_d = (body_byte_i == 8'd0) ? PH_ID : PH_BODY;
      end
      PH_BODY: begin
        if (!err_q) begin
          if (eid_q == EID_SSID) begin
            ssid_we = !widx_q[SLEN_W-1];
            widx_d  = widx_q + 1'b1;
          end else if (eid_q == EID_CHANNEL) begin
            chan_d = body_byte_i;
          end else if (eid_q == EID_RATES || eid_q == EID_EXT_RATES) begin
            if (rate < 7'(RATE_IGNORE_MIN)) rates_d[rate] = 1'b1;
          end
        end
        rem_d = rem_q - 1'b1;
        if (rem_d == 8'd0) phase_d = PH_ID;
      end
      default: ;
    endcase
  end

  // Build the record from the state as it stands after this byte.
  always_comb begin
    probe_ok = (frame_subtype_i == SUBTYPE_PROBE_RESP) && (phase_d == PH_ID) && !err_d;
    auth_ok  = (frame_subtype_i == SUBTYPE_AUTH) && (count_d >= COUNT_BITS'(AUTH_LEN));
    rec_push_o = accept_i && last_byte_i && !rej_d && (probe_ok || auth_ok);
    rec_o.kind  = probe_ok ? KIND_PROBE : KIND_AUTH;
    rec_o.word0 = probe_ok ? {18'd0, 6'(slen_d), chan_d, fixed_d} : {16'd0, auth_d};
    rec_o.bssid = bssid_address_i;
    rec_o.rates = rates_d;
    rec_o.ssid  = '0;
    for (int p = 0; p < SSID_BYTES; p++) begin
      ssid_byte = (ssid_we && widx_q[SIDX_W-1:0] == SIDX_W'(p)) ? body_byte_i : ssid_q[p];
      if (SLEN_W'(p) < slen_d) rec_o.ssid[8*p +: 8] = ssid_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= '0;
      count_q <= '0;
      phase_q <= PH_FIXED;
      eid_q   <= '0;
      rem_q   <= '0;
      widx_q  <= '0;
      rej_q   <= 1'b0;
      err_q   <= 1'b0;
      chan_q  <= '0;
      slen_q  <= '0;
      rates_q <= '0;
    end else begin
      if (cfg_we_i) own_q <= cfg_data_i;
      if (accept_i) begin
        if (last_byte_i) begin
          count_q <= '0;
          phase_q <= PH_FIXED;
          eid_q   <= '0;
          rem_q   <= '0;
          widx_q  <= '0;
          rej_q   <= 1'b0;
          err_q   <= 1'b0;
          chan_q  <= '0;
          slen_q  <= '0;
          rates_q <= '0;
        end else begin
          count_q <= count_d;
          phase_q <= phase_d;
          eid_q   <= eid_d;
          rem_q   <= rem_d;
          widx_q  <= widx_d;
          rej_q   <= rej_d;
          err_q   <= err_d;
          chan_q  <= chan_d;
          slen_q  <= slen_d;
          rates_q <= rates_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      fixed_q <= fixed_d;
      auth_q  <= auth_d;
      if (ssid_we) ssid_q[widx_q[SIDX_W-1:0]] <= body_byte_i;
    end
  end

`ifndef SYNTHESIS
  // Every frame end returns the parser to the start of a new body.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_byte_i) |=> (count_q == '0 && phase_q == PH_FIXED && !rej_q))
    else $error("parser state not cleared after frame end");
`endif

endmodule

`default_nettype wire

/* rtl/core/mfiep_rec_fifo.sv */
`default_nettype none

module mfiep_rec_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mfiep_pkg::rec_t  rec_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output mfiep_pkg::rec_t       rec_o,
  output logic                  empty_o
);
  import mfiep_pkg::*;

  localparam int unsigned PTR_W = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(REC_DEPTH + 1);

  rec_t             mem_q [REC_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(REC_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(REC_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(REC_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= rec_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("record queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("record queue read while empty");
`endif

endmodule

`default_nettype wire

/* rtl/core/mfiep_back.sv */
`default_nettype none

module mfiep_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mfiep_pkg::rec_t               head_i,
  input  wire logic                          head_empty_i,
  output logic                               head_pop_o,
  input  wire logic                          pop_i,
  output logic                               empty_o,
  output logic                               record_kind_o,
  output logic [2:0]                         word_index_o,
  output logic [mfiep_pkg::WORD_W-1:0]       data_word_o,
  output logic                               last_word_o
);
  import mfiep_pkg::*;

  logic              out_valid_q;
  kind_e             kind_q;
  logic [2:0]        idx_q;
  logic [WORD_W-1:0] data_q;
  logic              last_q;
  logic [2:0]        wcnt_q;
  logic              load;
  logic              is_last;
  logic [1:0]        ssid_sel;
  logic [WORD_W-1:0] word;

  always_comb begin
    ssid_sel = 2'(wcnt_q - WORD_SSID0);
    case (wcnt_q)
      WORD_FIXED:   word = head_i.word0;
      WORD_BSSID:   word = {{(WORD_W - ADDR_W){1'b0}}, head_i.bssid};
      WORD_RATE_LO: word = head_i.rates[WORD_W-1:0];
      WORD_RATE_HI: word = head_i.rates[2*WORD_W-1:WORD_W];
      default:      word = head_i.ssid[ssid_sel*WORD_W +: WORD_W];
    endcase
    is_last = (head_i.kind == KIND_PROBE) ? (wcnt_q == WORD_LAST_PROBE)
                                          : (wcnt_q == WORD_LAST_AUTH);
    load       = !head_empty_i && (!out_valid_q || pop_i);
    head_pop_o = load && is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      wcnt_q      <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        wcnt_q      <= is_last ? '0 : wcnt_q + 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind;
      idx_q  <= wcnt_q;
      data_q <= word;
      last_q <= is_last;
    end
  end

  assign empty_o       = !out_valid_q;
  assign record_kind_o = kind_q;
  assign word_index_o  = idx_q;
  assign data_word_o   = data_q;
  assign last_word_o   = last_q;

`ifndef SYNTHESIS
  // The final word of a record sits at the position its kind calls for.
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |->
      ((kind_q == KIND_PROBE && idx_q == WORD_LAST_PROBE) ||
       (kind_q == KIND_AUTH && idx_q == WORD_LAST_AUTH)))
    else $error("record ends at the wrong word");

  // Inside a record the next word follows at once with the next position.
  a_word_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pop_i && !last_q) |=>
      (out_valid_q && idx_q == $past(idx_q) + 3'd1))
    else $error("record word missing or out of order");
`endif

endmodule

`default_nettype wire

/* rtl/core/mgmt_frame_ie_parser.sv */
`default_nettype none

// Receive-side parser for management frame bodies, one body byte per request.
// Input channel: a byte is taken on a rising edge with push high and full low;
// subtype and the three header addresses ride along with every byte, and
// last_byte_i closes the frame. Bytes are taken every cycle: full only rises
// when two parsed frames are already waiting for the result side.
// Result channel: while empty is low the oldest record word is on the result
// ports, and pop high takes it. A probe response gives eight words, an
// authentication frame two; rejected, malformed, short or other frames give
// none. A record's first word passes from the record queue into the output
// register, and the words then follow one per cycle as long as pop stays
// high. The rate is one byte per cycle while full is low, and a two-entry
// record queue between parser and word sequencer lets both run on their own.
// If the receiver stalls, words wait in the output register, records pile up
// in the queue, and full rises once the queue holds two records.
// The own-address register is written on cfg_valid_i and always ready; write
// it only between frames. Reset clears the parse state, the queue, the output
// and the own address.
module mgmt_frame_ie_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mfiep_pkg::ADDR_W-1:0]  cfg_data_i,
  // Byte channel.
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [3:0]                    frame_subtype_i,
  input  wire logic [mfiep_pkg::ADDR_W-1:0]  receiver_address_i,
  input  wire logic [mfiep_pkg::ADDR_W-1:0]  transmitter_address_i,
  input  wire logic [mfiep_pkg::ADDR_W-1:0]  bssid_address_i,
  input  wire logic [7:0]                    body_byte_i,
  input  wire logic                          last_byte_i,
  // Record word channel.
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               record_kind_o,
  output logic [2:0]                         word_index_o,
  output logic [mfiep_pkg::WORD_W-1:0]       data_word_o,
  output logic                               last_word_o
);
  import mfiep_pkg::*;

  logic accept;
  logic rec_push;
  rec_t rec_in;
  rec_t rec_head;
  logic rec_full;
  logic rec_empty;
  logic rec_pop;

  // The register is a plain flop, so writes never have to wait.
  assign cfg_ready_o = 1'b1;

  // The byte side only backs off when the record queue has no room left.
  assign full   = rec_full;
  assign accept = push && !rec_full;

  // Parser: walks fixed fields and elements, and builds a record at frame end.
  mfiep_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_valid_i && cfg_ready_o),
    .cfg_data_i            (cfg_data_i),
    .accept_i              (accept),
    .frame_subtype_i       (frame_subtype_i),
    .receiver_address_i    (receiver_address_i),
    .transmitter_address_i (transmitter_address_i),
    .bssid_address_i       (bssid_address_i),
    .body_byte_i           (body_byte_i),
    .last_byte_i           (last_byte_i),
    .rec_push_o            (rec_push),
    .rec_o                 (rec_in)
  );

  // Finished records wait here until the sequencer has sent them out.
  mfiep_rec_fifo u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .rec_o   (rec_head),
    .empty_o (rec_empty)
  );

  // Word sequencer: turns the oldest record into words through an output
  // register, so a stalled receiver never holds up the parser directly.
  mfiep_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (rec_head),
    .head_empty_i  (rec_empty),
    .head_pop_o    (rec_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .record_kind_o (record_kind_o),
    .word_index_o  (word_index_o),
    .data_word_o   (data_word_o),
    .last_word_o   (last_word_o)
  );

endmodule

`default_nettype wire
